// File: sv/masc_pkg.sv
// Package with the shared types, codes and constants of the multi-alarm snooze controller.
package masc_pkg;

    localparam int MAX_ALARMS_DEF = 16;

    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int WDAY_W   = 3;
    localparam int IDX_W    = 4;
    localparam int DAYS_W   = 8;
    localparam int NUM_W    = 5;
    localparam int SCALE_W  = 8;
    localparam int RING_W   = 5;
    localparam int CD_W     = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [CD_W-1:0] HOLD_TICKS  = CD_W'(60);
    localparam logic [CD_W-1:0] SNOOZE_UNIT = CD_W'(60 * 2000);
    localparam logic [NUM_W-1:0] ONE_SHOT_RESET = NUM_W'(5);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ALARMS   = 2'd0,
        CFG_SNOOZE_SCALE = 2'd1,
        CFG_ONE_SHOT     = 2'd2
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RING     = 7'b0000010,
        PH_OK_HOLD  = 7'b0000100,
        PH_DISMISS  = 7'b0001000,
        PH_INC_HOLD = 7'b0010000,
        PH_SNZ_WAIT = 7'b0100000,
        PH_SNOOZE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic               command;
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [WDAY_W-1:0]  weekday;
        logic               ok_button;
        logic               inc_button;
        logic [IDX_W-1:0]   entry_index;
        logic [DAYS_W-1:0]  day_mask;
    } t_in_item;

    typedef struct packed {
        logic              alarm_active;
        logic [RING_W-1:0] ringing_count;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_link;

    typedef struct packed {
        logic [NUM_W-1:0] num_alarms;
        logic [NUM_W-1:0] one_shot_start;
        logic [CD_W-1:0]  snooze_len;
    } t_cell_cfg;

endpackage

// File: sv/masc_cell.sv
// One alarm entry cell: holds its entry state, steps it as an item passes, and forwards the item.
module masc_cell #(
    parameter int MAX_ALARMS = masc_pkg::MAX_ALARMS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int CNT_W     = $clog2(MAX_ALARMS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  masc_pkg::t_cell_cfg   i_cfg,
    input  masc_pkg::t_link       i_link,
    input  logic [CNT_W-1:0]      i_count,
    output masc_pkg::t_link       o_link,
    output logic [CNT_W-1:0]      o_count
);

    localparam logic [31:0] CELL_ID = 32'(CELL_IDX);

    logic [masc_pkg::HOUR_W-1:0] r_hour, n_hour;
    logic [masc_pkg::MIN_W-1:0]  r_minute, n_minute;
    logic [masc_pkg::DAYS_W-1:0] r_days, n_days;
    logic [masc_pkg::CD_W-1:0]   r_cd, n_cd;
    masc_pkg::t_phase            r_phase, n_phase;
    masc_pkg::t_link             r_link;
    logic [CNT_W-1:0]            r_count;

    logic                        w_active;
    logic                        w_one_shot;
    logic                        w_hit;
    logic                        w_match;
    logic [CNT_W-1:0]            w_count;

    assign w_active   = 32'(i_cfg.num_alarms) > CELL_ID;
    assign w_one_shot = CELL_ID >= 32'(i_cfg.one_shot_start);
    assign w_match    = 32'(i_link.item.entry_index) == CELL_ID;
    assign w_hit      = (r_hour == i_link.item.hours) && (r_minute == i_link.item.minutes)
                        && r_days[i_link.item.weekday] && (i_link.item.seconds == '0);

    always_comb begin
        logic [masc_pkg::CD_W-1:0] v_cd;
        logic                      ok;
        logic                      inc;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_days   = r_days;
        n_phase  = r_phase;
        n_cd     = r_cd;
        v_cd     = r_cd;
        ok       = i_link.item.ok_button;
        inc      = i_link.item.inc_button;
        if (i_link.item.command == masc_pkg::CMD_WRITE) begin
            if (w_match) begin
                n_hour   = i_link.item.hours;
                n_minute = i_link.item.minutes;
                n_days   = i_link.item.day_mask;
                n_phase  = masc_pkg::PH_IDLE;
                n_cd     = '0;
            end
        end else if (w_active) begin
            unique case (r_phase)
                masc_pkg::PH_IDLE: begin
                    if (w_hit) begin
                        n_phase = masc_pkg::PH_RING;
                    end
                end
                masc_pkg::PH_RING: begin
                    if (ok) begin
                        v_cd    = masc_pkg::HOLD_TICKS;
                        n_phase = masc_pkg::PH_OK_HOLD;
                    end else if (inc) begin
                        v_cd    = masc_pkg::HOLD_TICKS;
                        n_phase = masc_pkg::PH_INC_HOLD;
                    end
                end
                masc_pkg::PH_OK_HOLD: begin
                    if ((r_cd != '0) && !ok) begin
                        n_phase = masc_pkg::PH_RING;
                    end else if ((r_cd == '0) && ok) begin
                        if (w_one_shot) begin
                            n_days = '0;
                        end
                        n_phase = masc_pkg::PH_DISMISS;
                    end
                end
                masc_pkg::PH_DISMISS: begin
                    if (!ok) begin
                        n_phase = masc_pkg::PH_IDLE;
                    end
                end
                masc_pkg::PH_INC_HOLD: begin
                    if ((r_cd != '0) && !inc) begin
                        n_phase = masc_pkg::PH_RING;
                    end else if ((r_cd == '0) && inc) begin
                        n_phase = masc_pkg::PH_SNZ_WAIT;
                    end
                end
                masc_pkg::PH_SNZ_WAIT: begin
                    if (!inc) begin
                        v_cd    = i_cfg.snooze_len;
                        n_phase = masc_pkg::PH_SNOOZE;
                    end
                end
                masc_pkg::PH_SNOOZE: begin
                    if (r_cd == '0) begin
                        n_phase = masc_pkg::PH_RING;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            n_cd = (v_cd != '0) ? v_cd - 1'b1 : '0;
        end
    end

    assign w_count = (w_active && (n_phase == masc_pkg::PH_RING))
                     ? i_count + CNT_W'(1) : i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour       <= '0;
            r_minute     <= '0;
            r_days       <= '0;
            r_cd         <= '0;
            r_phase      <= masc_pkg::PH_IDLE;
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link.valid <= i_link.valid;
            r_link.item  <= i_link.item;
            r_count      <= w_count;
            if (i_link.valid) begin
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_days   <= n_days;
                r_cd     <= n_cd;
                r_phase  <= n_phase;
            end
        end
    end

    assign o_link  = r_link;
    assign o_count = r_count;

endmodule

// File: sv/multi_alarm_snooze_controller.sv
// Top level of the multi-alarm snooze controller: input stage, chain of entry cells, result register.
// A result passes the input stage, every entry cell and the result register before it is valid.
// The item walks the cell chain one entry cell per cycle while the chain is not frozen;
// one item is in the chain at a time, so a new item is taken only as the last one leaves it.
// A stalled result freezes the chain until the result transfer completes.
// Reset is synchronous and active low and restores every entry, the config and all valid flags.
module multi_alarm_snooze_controller #(
    parameter int MAX_ALARMS = masc_pkg::MAX_ALARMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  masc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output masc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [masc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [masc_pkg::SCALE_W-1:0]        i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ALARMS + 1);

    masc_pkg::t_cell_cfg  r_cfg;
    masc_pkg::t_link      r_in_link;
    logic                 r_busy;
    logic                 r_out_valid;
    masc_pkg::t_out_item  r_out;

    masc_pkg::t_link      w_link  [0:MAX_ALARMS];
    logic [CNT_W-1:0]     w_count [0:MAX_ALARMS];
    logic [MAX_ALARMS:0]  w_vld;
    logic                 w_in_accept;
    logic                 w_out_load;
    logic                 w_en;
    masc_pkg::t_link      w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_alarms     <= '0;
            r_cfg.one_shot_start <= masc_pkg::ONE_SHOT_RESET;
            r_cfg.snooze_len     <= masc_pkg::SNOOZE_UNIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (masc_pkg::t_cfg_idx'(i_cfg_index))
                masc_pkg::CFG_NUM_ALARMS: begin
                    r_cfg.num_alarms <= i_cfg_data[masc_pkg::NUM_W-1:0];
                end
                masc_pkg::CFG_SNOOZE_SCALE: begin
                    r_cfg.snooze_len <= masc_pkg::CD_W'(i_cfg_data) * masc_pkg::SNOOZE_UNIT;
                end
                masc_pkg::CFG_ONE_SHOT: begin
                    r_cfg.one_shot_start <= i_cfg_data[masc_pkg::NUM_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign w_last      = w_link[MAX_ALARMS];
    assign w_out_load  = w_last.valid && (!r_out_valid || !i_out_stall);
    assign w_en        = !w_last.valid || w_out_load;
    assign o_in_stall  = r_busy && !w_out_load;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_link.valid <= 1'b0;
            r_busy          <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_link.valid <= 1'b1;
                r_in_link.item  <= i_in_item;
                r_busy          <= 1'b1;
            end else begin
                if (w_en) begin
                    r_in_link.valid <= 1'b0;
                end
                if (w_out_load) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign w_link[0]  = r_in_link;
    assign w_count[0] = '0;

    for (genvar gi = 0; gi < MAX_ALARMS; gi++) begin : g_cell
        masc_cell #(
            .MAX_ALARMS (MAX_ALARMS),
            .CELL_IDX   (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (r_cfg),
            .i_link  (w_link[gi]),
            .i_count (w_count[gi]),
            .o_link  (w_link[gi+1]),
            .o_count (w_count[gi+1])
        );
    end

    for (genvar gv = 0; gv <= MAX_ALARMS; gv++) begin : g_vld
        assign w_vld[gv] = w_link[gv].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.alarm_active  <= w_count[MAX_ALARMS] != '0;
            r_out.ringing_count <= masc_pkg::RING_W'(w_count[MAX_ALARMS]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_one_item_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("More than one item travels the cell chain.");

    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_vld == '0))
        else $error("Cell chain holds an item while the block is idle.");

    a_accept_enters_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_in_link.valid && r_busy))
        else $error("Accepted transfer did not enter the cell chain.");

    a_result_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !w_in_accept) |=> !r_busy)
        else $error("Block stays busy after its result left the chain.");

endmodule

// File: sim/ring_count_checker.sv
// Checker for the alarm controller: predicts each result from the input transfers and compares.
module ring_count_checker
    import masc_pkg::*;
#(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_RINGING  = 2'd1,
        ST_SNOOZED  = 2'd2
    } t_entry_status;

    logic [NUM_W-1:0]   cfg_num;
    logic [SCALE_W-1:0] cfg_scale;
    logic [NUM_W-1:0]   cfg_one_shot;

    logic [HOUR_W-1:0]  wake_hour      [MAX_ALARMS];
    logic [MIN_W-1:0]   wake_minute    [MAX_ALARMS];
    logic [DAYS_W-1:0]  wake_days      [MAX_ALARMS];
    t_phase             wake_phase     [MAX_ALARMS];
    logic [CD_W-1:0]    wake_countdown [MAX_ALARMS];
    t_entry_status      wake_status    [MAX_ALARMS];

    t_out_item ring_reports[$];
    int        mismatches = 0;
    int        waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_out_item step_alarm_table(input t_in_item it);
        int        span;
        int        rings;
        logic      hit;
        t_out_item res;
        span  = (int'(cfg_num) > MAX_ALARMS) ? MAX_ALARMS : int'(cfg_num);
        rings = 0;
        if (it.command == CMD_WRITE) begin
            if (int'(it.entry_index) < MAX_ALARMS) begin
                wake_hour[it.entry_index]      = it.hours;
                wake_minute[it.entry_index]    = it.minutes;
                wake_days[it.entry_index]      = it.day_mask;
                wake_phase[it.entry_index]     = PH_IDLE;
                wake_countdown[it.entry_index] = '0;
                wake_status[it.entry_index]    = ST_NONE;
            end
        end else begin
            for (int i = 0; i < span; i++) begin
                case (wake_phase[i])
                    PH_IDLE: begin
                        hit = wake_hour[i] == it.hours && wake_minute[i] == it.minutes &&
                              wake_days[i][it.weekday] && it.seconds == '0;
                        wake_status[i] = hit ? ST_RINGING : ST_NONE;
                        if (hit) begin
                            wake_phase[i] = PH_RING;
                        end
                    end
                    PH_RING: begin
                        if (it.ok_button) begin
                            wake_countdown[i] = HOLD_TICKS;
                            wake_phase[i] = PH_OK_HOLD;
                        end else if (it.inc_button) begin
                            wake_countdown[i] = HOLD_TICKS;
                            wake_phase[i] = PH_INC_HOLD;
                        end
                    end
                    PH_OK_HOLD: begin
                        if (wake_countdown[i] != '0 && !it.ok_button) begin
                            wake_phase[i] = PH_RING;
                        end else if (wake_countdown[i] == '0 && it.ok_button) begin
                            if (i >= int'(cfg_one_shot)) begin
                                wake_days[i] = '0;
                            end
                            wake_status[i] = ST_NONE;
                            wake_phase[i] = PH_DISMISS;
                        end
                    end
                    PH_DISMISS: begin
                        if (!it.ok_button) begin
                            wake_phase[i] = PH_IDLE;
                        end
                    end
                    PH_INC_HOLD: begin
                        if (wake_countdown[i] != '0 && !it.inc_button) begin
                            wake_phase[i] = PH_RING;
                        end else if (wake_countdown[i] == '0 && it.inc_button) begin
                            wake_status[i] = ST_SNOOZED;
                            wake_phase[i] = PH_SNZ_WAIT;
                        end
                    end
                    PH_SNZ_WAIT: begin
                        if (!it.inc_button) begin
                            wake_countdown[i] = CD_W'(cfg_scale) * SNOOZE_UNIT;
                            wake_phase[i] = PH_SNOOZE;
                        end
                    end
                    PH_SNOOZE: begin
                        if (wake_countdown[i] == '0) begin
                            wake_status[i] = ST_RINGING;
                            wake_phase[i] = PH_RING;
                        end
                    end
                    default: begin
                    end
                endcase
                if (wake_countdown[i] != '0) begin
                    wake_countdown[i] = wake_countdown[i] - 1'b1;
                end
            end
        end
        for (int i = 0; i < span; i++) begin
            if (wake_phase[i] == PH_RING) begin
                rings++;
            end
        end
        res.alarm_active  = (rings != 0);
        res.ringing_count = RING_W'(rings);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_num      = '0;
            cfg_scale    = SCALE_W'(1);
            cfg_one_shot = ONE_SHOT_RESET;
            for (int i = 0; i < MAX_ALARMS; i++) begin
                wake_hour[i]      = '0;
                wake_minute[i]    = '0;
                wake_days[i]      = '0;
                wake_phase[i]     = PH_IDLE;
                wake_countdown[i] = '0;
                wake_status[i]    = ST_NONE;
            end
            ring_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_ALARMS:   cfg_num = NUM_W'(i_cfg_data);
                    CFG_SNOOZE_SCALE: cfg_scale = i_cfg_data;
                    CFG_ONE_SHOT:     cfg_one_shot = NUM_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (ring_reports.size() == 0) begin
                    $error("unexpected result transfer: alarm_active %0d, ringing_count %0d",
                           i_out_item.alarm_active, i_out_item.ringing_count);
                    mismatches++;
                end else begin
                    want = ring_reports.pop_front();
                    if (i_out_item.alarm_active !== want.alarm_active) begin
                        $error("alarm_active: expected %0d, actual %0d",
                               want.alarm_active, i_out_item.alarm_active);
                        mismatches++;
                    end
                    if (i_out_item.ringing_count !== want.ringing_count) begin
                        $error("ringing_count: expected %0d, actual %0d",
                               want.ringing_count, i_out_item.ringing_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ring_reports.push_back(step_alarm_table(i_in_item));
            end
        end
        waiting <= ring_reports.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the alarm controller testbench: clock, reset, stimulus, configuration and verdict.
module testbench;
    import masc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    bit calm = 1'b0;

    logic [HOUR_W-1:0] plan_hour [MAX_ALARMS_DEF];
    logic [MIN_W-1:0]  plan_min  [MAX_ALARMS_DEF];
    logic [DAYS_W-1:0] plan_days [MAX_ALARMS_DEF];
    int                plan_span = 0;

    always #10 clk = ~clk;

    multi_alarm_snooze_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ring_count_checker ring_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send(input t_in_item it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic tick(input logic [HOUR_W-1:0] hh, input logic [MIN_W-1:0] mm,
                        input logic [SEC_W-1:0] ss, input logic [WDAY_W-1:0] wd,
                        input logic ok, input logic inc);
        t_in_item it;
        it.command     = CMD_TICK;
        it.hours       = hh;
        it.minutes     = mm;
        it.seconds     = ss;
        it.weekday     = wd;
        it.ok_button   = ok;
        it.inc_button  = inc;
        it.entry_index = IDX_W'($urandom);
        it.day_mask    = DAYS_W'($urandom);
        send(it);
    endtask

    task automatic write_entry(input int idx, input logic [HOUR_W-1:0] hh,
                               input logic [MIN_W-1:0] mm, input logic [DAYS_W-1:0] days);
        t_in_item it;
        it.command     = CMD_WRITE;
        it.hours       = hh;
        it.minutes     = mm;
        it.seconds     = SEC_W'($urandom);
        it.weekday     = WDAY_W'($urandom);
        it.ok_button   = 1'($urandom);
        it.inc_button  = 1'($urandom);
        it.entry_index = IDX_W'(idx);
        it.day_mask    = days;
        plan_hour[idx] = hh;
        plan_min[idx]  = mm;
        plan_days[idx] = days;
        send(it);
    endtask

    task automatic noise_tick(input logic ok, input logic inc);
        tick(HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom), WDAY_W'($urandom),
             ok, inc);
    endtask

    task automatic random_write(input int idx);
        logic [DAYS_W-1:0] days;
        case ($urandom_range(0, 3))
            0: days = '1;
            1: days = DAYS_W'(1) << $urandom_range(0, 7);
            default: days = DAYS_W'($urandom);
        endcase
        write_entry(idx, HOUR_W'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 31 : 23)),
                    MIN_W'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 63 : 59)), days);
    endtask

    function automatic int pick_entry();
        return (plan_span == 0) ? $urandom_range(0, MAX_ALARMS_DEF - 1)
                                : $urandom_range(0, plan_span - 1);
    endfunction

    task automatic ring_entry(input int k);
        logic [WDAY_W-1:0] wd;
        wd = WDAY_W'($urandom);
        for (int t = 0; t < 8 && !plan_days[k][wd]; t++) begin
            wd = wd + 1'b1;
        end
        tick(plan_hour[k], plan_min[k], '0, wd,
             $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
    endtask

    task automatic hold_button(input bit use_ok);
        int len;
        len = ($urandom_range(0, 2) != 0) ? $urandom_range(61, 66) : $urandom_range(1, 70);
        repeat (len) begin
            if (use_ok) begin
                noise_tick(1'b1, $urandom_range(0, 3) == 0);
            end else begin
                noise_tick($urandom_range(0, 15) == 0, 1'b1);
            end
        end
        repeat ($urandom_range(1, 3)) noise_tick(1'b0, 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic apply_settings(input logic [NUM_W-1:0] num, input logic [SCALE_W-1:0] scale,
                                  input logic [NUM_W-1:0] first_one_shot);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_ALARMS;
        cfg_data  <= SCALE_W'(num);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_SNOOZE_SCALE;
        cfg_data  <= scale;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_ONE_SHOT;
        cfg_data  <= SCALE_W'(first_one_shot);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_span = (int'(num) > MAX_ALARMS_DEF) ? MAX_ALARMS_DEF : int'(num);
    endtask

    task automatic random_run(input int count, input bit keep_calm);
        int target;
        int k;
        target = items_sent + count;
        while (items_sent < target) begin
            calm = keep_calm || ($urandom_range(0, 3) == 0);
            k = pick_entry();
            case ($urandom_range(0, 9))
                0, 1: random_write(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : k);
                2, 3: begin
                    ring_entry(k);
                    repeat ($urandom_range(0, 2)) noise_tick(1'($urandom), 1'($urandom));
                end
                4, 5: begin
                    ring_entry(k);
                    hold_button(1'b1);
                end
                6, 7: begin
                    ring_entry(k);
                    hold_button(1'b0);
                end
                8: repeat ($urandom_range(1, 5)) noise_tick(1'($urandom), 1'($urandom));
                default: begin
                    random_write(k);
                    ring_entry(k);
                end
            endcase
        end
    endtask

    initial begin
        while (1) begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #(20 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAX_ALARMS_DEF; i++) begin
            plan_hour[i] = '0;
            plan_min[i]  = '0;
            plan_days[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset table size nothing is walked, so a matching tick reports no ringing.
        write_entry(0, 23, 59, 8'h80);
        tick(23, 59, 0, 7, 1'b0, 1'b0);

        apply_settings(16, 0, 5);
        write_entry(15, 0, 0, 8'h01);
        tick(23, 59, 0, 7, 1'b0, 1'b0);
        tick(0, 0, 0, 0, 1'b0, 1'b0);
        write_entry(5, 12, 30, 8'hFF);
        tick(12, 30, 1, 3, 1'b0, 1'b0);
        tick(12, 30, 0, 3, 1'b0, 1'b0);
        tick(12, 31, 0, 3, 1'b0, 1'b0);
        write_entry(15, 31, 63, 8'h00);
        tick(12, 30, 0, 3, 1'b1, 1'b1);
        tick(12, 30, 59, 6, 1'b0, 1'b0);
        tick(1, 2, 3, 4, 1'b0, 1'b1);
        tick(31, 63, 63, 7, 1'b0, 1'b0);
        tick(31, 63, 0, 2, 1'b0, 1'b0);
        write_entry(3, 31, 63, 8'h04);
        tick(31, 63, 0, 2, 1'b0, 1'b0);

        apply_settings(16, 0, 5);
        random_run(230, 1'b0);
        apply_settings(5, 255, 0);
        random_run(230, 1'b0);
        apply_settings(31, 0, 16);
        random_run(230, 1'b0);
        apply_settings(0, 255, 16);
        random_run(40, 1'b0);
        apply_settings(12, 1, 8);
        random_run(60, 1'b0);
        apply_settings(16, 0, 0);
        random_run(360, 1'b1);

        settle();
        repeat (2 * (MAX_ALARMS_DEF + 1)) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
